FILE: design/dsa_pkg.sv
`timescale 1ns / 1ps

package dsa_pkg;

  // Table geometry and field widths.
  localparam int SLOT_COUNT = 1024;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int DATA_W     = 64;
  localparam int STRIDE_W   = 16;
  localparam int PROD_W     = IDX_W + STRIDE_W;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;

  // The divider retires one quotient bit per cycle.
  localparam int DIV_STEPS  = DATA_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0]    SLOT_COUNT_C = CNT_W'(SLOT_COUNT);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE = CFG_IDX_W'(2);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Sequencer to free-index stack.
  typedef struct packed {
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_idx;
  } stk_req_t;

  // Free-index stack to sequencer.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] pop_idx;
  } stk_rsp_t;

  // Sequencer to divider.
  typedef struct packed {
    logic                start;
    logic [STRIDE_W-1:0] divisor;
    logic [DATA_W-1:0]   dividend_a;
    logic [DATA_W-1:0]   dividend_b;
  } div_req_t;

  // Divider to sequencer.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quo_a;
    logic [DATA_W-1:0] quo_b;
  } div_rsp_t;

endpackage

FILE: design/dsa_chan_if.sv
`timescale 1ns / 1ps

// Request channel: one allocate or free per transaction.
interface dsa_in_if;
  import dsa_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] cpu_handle_in;
  logic [DATA_W-1:0] gpu_handle_in;

  modport source (output valid, op, cpu_handle_in, gpu_handle_in, input ready);
  modport sink   (input valid, op, cpu_handle_in, gpu_handle_in, output ready);
endinterface

// Response channel: one result per request.
interface dsa_out_if;
  import dsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   cpu_handle_out;
  logic [DATA_W-1:0]   gpu_handle_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, cpu_handle_out, gpu_handle_out, status, input ready);
  modport sink   (input valid, cpu_handle_out, gpu_handle_out, status, output ready);
endinterface

FILE: design/dsa_stack.sv
`timescale 1ns / 1ps

module dsa_stack (
  input  logic             clk,
  input  logic             rst_n,
  input  dsa_pkg::stk_req_t req,
  output dsa_pkg::stk_rsp_t rsp
);
  import dsa_pkg::*;

  logic [IDX_W-1:0] mem [SLOT_COUNT];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] lwm_r;
  logic [CNT_W-1:0] lwm_nxt;
  logic [CNT_W-1:0] top_pos;
  logic [IDX_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic             rd_unwritten_r;

  assign top_pos = count_r - CNT_W'(1);

  // The low-water mark is the smallest fill level seen since reset. Every
  // position below it has never been written and reads back as its own index.
  always_comb begin
    count_nxt = count_r;
    lwm_nxt   = lwm_r;
    if (req.pop) begin
      count_nxt = top_pos;
      if (top_pos < lwm_r) begin
        lwm_nxt = top_pos;
      end
    end else if (req.push) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= SLOT_COUNT_C;
      lwm_r   <= SLOT_COUNT_C;
    end else begin
      count_r <= count_nxt;
      lwm_r   <= lwm_nxt;
    end
  end

  // Single-port style storage with a registered read.
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[count_r[IDX_W-1:0]] <= req.push_idx;
    end
    if (req.pop) begin
      rd_data_r      <= mem[top_pos[IDX_W-1:0]];
      rd_addr_r      <= top_pos[IDX_W-1:0];
      rd_unwritten_r <= top_pos < lwm_r;
    end
  end

  assign rsp.count   = count_r;
  assign rsp.pop_idx = rd_unwritten_r ? rd_addr_r : rd_data_r;

endmodule

FILE: design/dsa_div.sv
`timescale 1ns / 1ps

module dsa_div (
  input  logic             clk,
  input  logic             rst_n,
  input  dsa_pkg::div_req_t req,
  output dsa_pkg::div_rsp_t rsp
);
  import dsa_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [STRIDE_W-1:0] dvs_r;
  logic [DATA_W-1:0]   quo_r [2];
  logic [STRIDE_W-1:0] rem_r [2];
  logic [STRIDE_W:0]   trial [2];
  logic [STRIDE_W:0]   diff  [2];
  logic                take  [2];

  // Restoring division, two lanes sharing one divisor. Each lane shifts the
  // next dividend bit into its remainder and subtracts where it fits.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_r[l], quo_r[l][DATA_W-1]};
      diff[l]  = trial[l] - {1'b0, dvs_r};
      take[l]  = trial[l] >= {1'b0, dvs_r};
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_STEPS);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend registers turn into quotient registers one bit per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs_r    <= req.divisor;
      quo_r[0] <= req.dividend_a;
      quo_r[1] <= req.dividend_b;
      rem_r[0] <= '0;
      rem_r[1] <= '0;
    end else if (busy_r) begin
      for (int l = 0; l < 2; l++) begin
        rem_r[l] <= take[l] ? diff[l][STRIDE_W-1:0] : trial[l][STRIDE_W-1:0];
        quo_r[l] <= {quo_r[l][DATA_W-2:0], take[l]};
      end
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.quo_a = quo_r[0];
  assign rsp.quo_b = quo_r[1];

endmodule

FILE: design/descriptor_slot_allocator.sv
// Allocate: pop, then the multiply and add states, then the response state.
// Allocate on an empty stack or free with zero stride: no arithmetic and no divider.
// Free: start, divide on the 64-step bit-serial divider, check, then respond.
// Reset: bases 0, stride 32, every slot free with the highest index on top.
// No clearing pass; the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module descriptor_slot_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  dsa_in_if.sink                           in_ch,
  dsa_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsa_pkg::DATA_W-1:0]       cfg_data
);
  import dsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_START,
    S_DIV,
    S_CHECK,
    S_RESP
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [DATA_W-1:0]   out_cpu_r;
  logic [DATA_W-1:0]   out_cpu_nxt;
  logic [DATA_W-1:0]   out_gpu_r;
  logic [DATA_W-1:0]   out_gpu_nxt;
  status_t             out_status_r;
  status_t             out_status_nxt;
  logic [DATA_W-1:0]   res_cpu_r;
  logic [DATA_W-1:0]   res_cpu_nxt;
  logic [DATA_W-1:0]   res_gpu_r;
  logic [DATA_W-1:0]   res_gpu_nxt;
  status_t             res_status_r;
  status_t             res_status_nxt;
  op_t                 op_r;
  op_t                 op_nxt;
  logic [DATA_W-1:0]   hin_cpu_r;
  logic [DATA_W-1:0]   hin_cpu_nxt;
  logic [DATA_W-1:0]   hin_gpu_r;
  logic [DATA_W-1:0]   hin_gpu_nxt;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   prod_nxt;

  logic [DATA_W-1:0]   cpu_base_r;
  logic [DATA_W-1:0]   gpu_base_r;
  logic [STRIDE_W-1:0] stride_r;

  logic                in_fire;
  stk_req_t            stk_req;
  stk_rsp_t            stk_rsp;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  dsa_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stk_req),
    .rsp   (stk_rsp)
  );

  dsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_base_r <= '0;
      gpu_base_r <= '0;
      stride_r   <= STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CPU_BASE:    cpu_base_r <= cfg_data;
        CFG_GPU_BASE:    gpu_base_r <= cfg_data;
        CFG_SLOT_STRIDE: stride_r   <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Requests to the stack and the divider.
  always_comb begin
    stk_req.pop        = in_fire && (op_t'(in_ch.op) == OP_ALLOC) && (stk_rsp.count != '0);
    stk_req.push       = 1'b0;
    stk_req.push_idx   = div_rsp.quo_a[IDX_W-1:0];
    div_req.start      = (state_r == S_START) && (stride_r != '0);
    div_req.divisor    = stride_r;
    div_req.dividend_a = hin_cpu_r - cpu_base_r;
    div_req.dividend_b = hin_gpu_r - gpu_base_r;
    if (state_r == S_CHECK) begin
      stk_req.push = (div_rsp.quo_a == div_rsp.quo_b)
                  && (div_rsp.quo_a < DATA_W'(SLOT_COUNT))
                  && (stk_rsp.count < SLOT_COUNT_C);
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_cpu_nxt    = out_cpu_r;
    out_gpu_nxt    = out_gpu_r;
    out_status_nxt = out_status_r;
    res_cpu_nxt    = res_cpu_r;
    res_gpu_nxt    = res_gpu_r;
    res_status_nxt = res_status_r;
    op_nxt         = op_r;
    hin_cpu_nxt    = hin_cpu_r;
    hin_gpu_nxt    = hin_gpu_r;
    prod_nxt       = prod_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = op_t'(in_ch.op);
          hin_cpu_nxt = in_ch.cpu_handle_in;
          hin_gpu_nxt = in_ch.gpu_handle_in;
          res_cpu_nxt = '0;
          res_gpu_nxt = '0;
          if (op_t'(in_ch.op) == OP_FREE) begin
            state_nxt = S_START;
          end else if (stk_rsp.count == '0) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(stk_rsp.pop_idx) * PROD_W'(stride_r);
        state_nxt = S_ADD;
      end
      S_ADD: begin
        res_cpu_nxt    = cpu_base_r + DATA_W'(prod_r);
        res_gpu_nxt    = gpu_base_r + DATA_W'(prod_r);
        res_status_nxt = ST_OK;
        state_nxt      = S_RESP;
      end
      S_START: begin
        if (stride_r == '0) begin
          res_status_nxt = ST_RANGE;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (div_rsp.quo_a != div_rsp.quo_b) begin
          res_status_nxt = ST_MISMATCH;
        end else if (div_rsp.quo_a >= DATA_W'(SLOT_COUNT)) begin
          res_status_nxt = ST_RANGE;
        end else if (stk_rsp.count >= SLOT_COUNT_C) begin
          res_status_nxt = ST_FULL;
        end else begin
          res_status_nxt = ST_OK;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_cpu_nxt    = res_cpu_r;
          out_gpu_nxt    = res_gpu_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    out_cpu_r    <= out_cpu_nxt;
    out_gpu_r    <= out_gpu_nxt;
    out_status_r <= out_status_nxt;
    res_cpu_r    <= res_cpu_nxt;
    res_gpu_r    <= res_gpu_nxt;
    res_status_r <= res_status_nxt;
    op_r         <= op_nxt;
    hin_cpu_r    <= hin_cpu_nxt;
    hin_gpu_r    <= hin_gpu_nxt;
    prod_r       <= prod_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cpu_handle_out = out_cpu_r;
  assign out_ch.gpu_handle_out = out_gpu_r;
  assign out_ch.status         = out_status_r;

`ifndef NO_ASSERTIONS
  // A pop is never issued against an empty stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    stk_req.pop |-> (stk_rsp.count != '0))
    else $error("pop issued on empty stack");

  // A push grows the fill level by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    stk_req.push |=> (stk_rsp.count == $past(stk_rsp.count) + CNT_W'(1)))
    else $error("push did not advance fill level");

  // No new request is taken while the divider is still working.
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_rsp.busy)
    else $error("ready raised while divider busy");

  // A result appears only from the response state.
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("result presented outside response state");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct packed {
    logic [DATA_W-1:0] cpu;
    logic [DATA_W-1:0] gpu;
    status_t           status;
  } answer_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] cpu_in;
    logic [DATA_W-1:0] gpu_in;
    bit                typed;
    answer_t           want;
  } request_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  dsa_in_if  in_ch ();
  dsa_out_if out_ch ();

  descriptor_slot_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the free-index stack and the registers.
  logic [IDX_W-1:0]    free_slots [SLOT_COUNT];
  int                  free_cnt;
  logic [DATA_W-1:0]   cpu_base_r;
  logic [DATA_W-1:0]   gpu_base_r;
  logic [STRIDE_W-1:0] stride_r;

  // Slots currently handed out, used to build well-formed frees.
  int      held_slots [$];
  answer_t pending_answers [$];
  int      mismatch_count;
  int      stall_cycles;
  bit      steady;

  // Opening directed sequence, run on the reset settings (bases 0, stride 32).
  request_row_t opening_script [18] = '{
    '{OP_FREE,  64'd0,     64'd0,     1'b1, '{64'd0,     64'd0,     ST_FULL}},
    '{OP_ALLOC, 64'd0,     64'd0,     1'b1, '{64'd32736, 64'd32736, ST_OK}},
    '{OP_ALLOC, '1,        '1,        1'b1, '{64'd32704, 64'd32704, ST_OK}},
    '{OP_FREE,  64'd32767, 64'd32736, 1'b1, '{64'd0,     64'd0,     ST_OK}},
    '{OP_FREE,  64'd32704, 64'd32736, 1'b1, '{64'd0,     64'd0,     ST_MISMATCH}},
    '{OP_FREE,  64'd32768, 64'd32768, 1'b1, '{64'd0,     64'd0,     ST_RANGE}},
    '{OP_FREE,  '1,        '1,        1'b1, '{64'd0,     64'd0,     ST_RANGE}},
    '{OP_FREE,  '1,        64'd0,     1'b1, '{64'd0,     64'd0,     ST_MISMATCH}},
    '{OP_FREE,  64'd32704, 64'd32704, 1'b1, '{64'd0,     64'd0,     ST_OK}},
    '{OP_FREE,  64'd32704, 64'd32704, 1'b1, '{64'd0,     64'd0,     ST_FULL}},
    '{OP_ALLOC, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
      '{64'd32704, 64'd32704, ST_OK}},
    '{OP_FREE,  64'd0,     64'd0,     1'b1, '{64'd0,     64'd0,     ST_OK}},
    '{OP_ALLOC, 64'd0,     64'd0,     1'b1, '{64'd0,     64'd0,     ST_OK}},
    '{OP_ALLOC, 64'd0,     64'd0,     1'b0, '0},
    '{OP_ALLOC, 64'd0,     64'd0,     1'b0, '0},
    '{OP_FREE,  64'd32677, 64'd32692, 1'b0, '0},
    '{OP_FREE,  64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
    '{OP_ALLOC, 64'd0,     64'd0,     1'b0, '0}
  };

  // Clock generation.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Works out the answer to one request and updates the stack copy.
  // slot returns the index popped or pushed, or -1 when nothing moved.
  function automatic answer_t predict_answer(input op_t op,
                                             input logic [DATA_W-1:0] cpu_h,
                                             input logic [DATA_W-1:0] gpu_h,
                                             output int slot);
    answer_t          a;
    logic [DATA_W-1:0] cpu_idx;
    logic [DATA_W-1:0] gpu_idx;
    a = '{cpu: '0, gpu: '0, status: ST_OK};
    slot = -1;
    if (op == OP_ALLOC) begin
      if (free_cnt == 0) begin
        a.status = ST_EMPTY;
      end else begin
        free_cnt--;
        slot = int'(free_slots[free_cnt]);
        a.cpu = cpu_base_r + 64'(slot) * 64'(stride_r);
        a.gpu = gpu_base_r + 64'(slot) * 64'(stride_r);
      end
    end else if (stride_r == '0) begin
      a.status = ST_RANGE;
    end else begin
      cpu_idx = (cpu_h - cpu_base_r) / 64'(stride_r);
      gpu_idx = (gpu_h - gpu_base_r) / 64'(stride_r);
      if (cpu_idx != gpu_idx) begin
        a.status = ST_MISMATCH;
      end else if (cpu_idx >= 64'(SLOT_COUNT)) begin
        a.status = ST_RANGE;
      end else if (free_cnt >= SLOT_COUNT) begin
        a.status = ST_FULL;
      end else begin
        free_slots[free_cnt] = cpu_idx[IDX_W-1:0];
        free_cnt++;
        slot = int'(cpu_idx);
      end
    end
    return a;
  endfunction

  // Handle of a slot on the current settings, now and then pushed off the
  // exact multiple so that the index gets truncated.
  function automatic logic [DATA_W-1:0] slot_handle(input logic [DATA_W-1:0] base,
                                                    input int slot);
    logic [DATA_W-1:0] skew;
    skew = '0;
    if (stride_r > 1 && $urandom_range(2) == 0)
      skew = 64'($urandom_range(int'(stride_r) - 1));
    return base + 64'(slot) * 64'(stride_r) + skew;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Drives one transaction, waits for acceptance and books the expected answer.
  task automatic send_request(input op_t op, input logic [DATA_W-1:0] cpu_h,
                              input logic [DATA_W-1:0] gpu_h, input bit typed,
                              input answer_t want);
    answer_t got;
    int      slot;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.cpu_handle_in <= cpu_h;
    in_ch.gpu_handle_in <= gpu_h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = predict_answer(op, cpu_h, gpu_h, slot);
    pending_answers.insert(pending_answers.size(), typed ? want : got);
    if (got.status == ST_OK) begin
      if (op == OP_ALLOC) begin
        held_slots.insert(held_slots.size(), slot);
      end else begin
        for (int k = 0; k < held_slots.size(); k++) begin
          if (held_slots[k] == slot) begin
            held_slots.delete(k);
            break;
          end
        end
      end
    end
  endtask

  // Builds one random request. Most frees return a slot that is held;
  // the rest are double frees, mismatched pairs, out-of-range and noise.
  task automatic make_request(input int alloc_pct, output op_t op,
                              output logic [DATA_W-1:0] cpu_h,
                              output logic [DATA_W-1:0] gpu_h);
    int pick;
    int slot;
    int other;
    cpu_h = {$urandom, $urandom};
    gpu_h = {$urandom, $urandom};
    op = OP_ALLOC;
    if ($urandom_range(99) < alloc_pct) return;
    op = OP_FREE;
    pick = $urandom_range(99);
    if (pick < 70 && held_slots.size() > 0) begin
      slot  = held_slots[$urandom_range(held_slots.size() - 1)];
      cpu_h = slot_handle(cpu_base_r, slot);
      gpu_h = slot_handle(gpu_base_r, slot);
    end else if (pick < 80) begin
      slot  = $urandom_range(SLOT_COUNT - 1);
      cpu_h = slot_handle(cpu_base_r, slot);
      gpu_h = slot_handle(gpu_base_r, slot);
    end else if (pick < 87) begin
      slot  = $urandom_range(SLOT_COUNT - 1);
      other = slot ^ (1 << $urandom_range(IDX_W - 1));
      if ($urandom_range(1) == 0) begin
        cpu_h = slot_handle(cpu_base_r, slot);
        gpu_h = slot_handle(gpu_base_r, other);
      end else begin
        cpu_h = slot_handle(cpu_base_r, other);
        gpu_h = slot_handle(gpu_base_r, slot);
      end
    end else if (pick < 94) begin
      slot  = $urandom_range(65535, SLOT_COUNT);
      cpu_h = slot_handle(cpu_base_r, slot);
      gpu_h = slot_handle(gpu_base_r, slot);
    end
  endtask

  // Waits until the block is idle, writes all three registers, then runs a
  // batch of random requests. With drain set it first empties the stack.
  task automatic run_phase(input logic [DATA_W-1:0] cpu_base,
                           input logic [DATA_W-1:0] gpu_base,
                           input logic [STRIDE_W-1:0] stride, input int items,
                           input int alloc_pct, input bit no_idle, input bit drain);
    op_t               op;
    logic [DATA_W-1:0] cpu_h;
    logic [DATA_W-1:0] gpu_h;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CPU_BASE;
    cfg_data  <= cpu_base;
    @(negedge clk);
    cfg_index <= CFG_GPU_BASE;
    cfg_data  <= gpu_base;
    @(negedge clk);
    // Bits above the stride field are don't-care for the register.
    cfg_index <= CFG_SLOT_STRIDE;
    cfg_data  <= {$urandom, 16'($urandom), stride};
    @(negedge clk);
    cfg_we     <= 1'b0;
    cpu_base_r = cpu_base;
    gpu_base_r = gpu_base;
    stride_r   = stride;
    steady     = no_idle;
    if (drain) begin
      while (free_cnt > 0) begin
        make_request(100, op, cpu_h, gpu_h);
        send_request(op, cpu_h, gpu_h, 1'b0, '0);
      end
    end
    repeat (items) begin
      make_request(alloc_pct, op, cpu_h, gpu_h);
      send_request(op, cpu_h, gpu_h, 1'b0, '0);
    end
  endtask

  // Result side: random back-pressure unless in a steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 6);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, status %0d",
                                  out_ch.status));
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.cpu_handle_out !== want.cpu)
          report_mismatch($sformatf("cpu handle %h, expected %h",
                                    out_ch.cpu_handle_out, want.cpu));
        if (out_ch.gpu_handle_out !== want.gpu)
          report_mismatch($sformatf("gpu handle %h, expected %h",
                                    out_ch.gpu_handle_out, want.gpu));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %s",
                                    out_ch.status, want.status.name()));
      end
    end
  end

  // Watchdog: too long without any transaction on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_CPU_BASE;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_ALLOC;
    in_ch.cpu_handle_in = '0;
    in_ch.gpu_handle_in = '0;
    out_ch.ready        = 1'b0;
    mismatch_count      = 0;
    stall_cycles        = 0;
    steady              = 1'b0;
    cpu_base_r          = '0;
    gpu_base_r          = '0;
    stride_r            = STRIDE_RESET;
    for (int i = 0; i < SLOT_COUNT; i++) free_slots[i] = IDX_W'(i);
    free_cnt = SLOT_COUNT;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed sequence on the reset settings.
    foreach (opening_script[i])
      send_request(opening_script[i].op, opening_script[i].cpu_in,
                   opening_script[i].gpu_in, opening_script[i].typed,
                   opening_script[i].want);

    // Random phases over several settings, extremes among them. The first
    // three lean on allocates so that the stack runs low.
    run_phase(64'd0, 64'd0, 16'd32, 200, 95, 1'b0, 1'b0);
    run_phase(64'hFFFF_FFFF_FFFF_F000, 64'h0000_0001_0000_0000, 16'd1, 200, 85,
              1'b1, 1'b0);
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 200, 95,
              1'b0, 1'b0);
    // Empty the stack, then keep hitting the empty and nearly empty cases.
    run_phase(64'h8000_0000_0000_0000, '1, 16'd48, 40, 60, 1'b0, 1'b1);
    // Zero stride: every allocate that finds a free slot answers with the bases, every free fails.
    run_phase({$urandom, $urandom}, {$urandom, $urandom}, 16'd0, 40, 50,
              1'b0, 1'b0);
    repeat (3)
      run_phase({$urandom, $urandom}, {$urandom, $urandom},
                16'($urandom_range(65535, 1)), 40, 40, 1'b0, 1'b0);
    run_phase('1, '1, 16'hFFFF, 40, 45, 1'b0, 1'b0);

    // Let the last answers come back, then watch for strays.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
